// ----- rtl/core/bpf_pkg.sv -----
// Package for the bin packing feasibility block.
// Holds the default sizes, the command codes and the structs that the
// top level and the search core exchange. No dependencies.
package bpf_pkg;

  localparam int MAX_BINS_DEF   = 8;
  localparam int MAX_ITEMS_DEF  = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  // Widths of the command and value fields on the input channel.
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_BIN  = 2'd0,
    CMD_LOAD_ITEM = 2'd1,
    CMD_CHECK     = 2'd2
  } cmd_t;

  // One accepted beat, decoded.
  typedef struct packed {
    logic load_bin;
    logic load_item;
    logic check;
  } req_t;

  // Status from the search core back to the top level.
  typedef struct packed {
    logic idle;
    logic done;
    logic feasible;
    logic dropped;
  } status_t;

endpackage

// ----- rtl/core/bpf_if.sv -----
// Channel interfaces of the bin packing feasibility block.
// Depends on bpf_pkg for the field widths.
interface bpf_in_if;
  logic                        valid;
  logic                        ready;
  logic [bpf_pkg::CMD_W-1:0]   command;
  logic [bpf_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface bpf_out_if;
  logic valid;
  logic ready;
  logic feasible;
  logic overflowed;

  modport source (output valid, output feasible, output overflowed, input ready);
  modport sink   (input valid, input feasible, input overflowed, output ready);
endinterface

// ----- rtl/core/bin_packing_feasibility.sv -----
// Bin loads, and item loads into an empty store, are written as they are taken; other item
// loads move each smaller stored size up one place until the new size lands. A check sums
// the item sizes and the bin rooms, then searches level by level: it skips bins too small,
// compares a fitting bin with each lower bin, and backtracks, run by one sequencer.
// The result beat is registered; loads are taken while it waits. Reset is synchronous,
// active low, and empties both stores and the overflow flag.
module bin_packing_feasibility #(
  parameter int MAX_BINS   = bpf_pkg::MAX_BINS_DEF,
  parameter int MAX_ITEMS  = bpf_pkg::MAX_ITEMS_DEF,
  parameter int SIZE_WIDTH = bpf_pkg::SIZE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bpf_in_if.sink    in_bus,
  bpf_out_if.source out_bus
);
  import bpf_pkg::*;

  req_t                          req;
  status_t                       status;
  logic                          in_accept;
  logic                          res_free;
  logic [SIZE_WIDTH+VALUE_W-1:0] value_ext;
  logic                          overflow_r;
  logic                          out_valid_r;
  logic                          out_feasible_r;
  logic                          out_overflowed_r;

  assign in_accept = in_bus.valid && in_bus.ready;
  assign value_ext = {{SIZE_WIDTH{1'b0}}, in_bus.value};

  always_comb begin
    req.load_bin  = in_accept && (cmd_t'(in_bus.command) == CMD_LOAD_BIN);
    req.load_item = in_accept && (cmd_t'(in_bus.command) == CMD_LOAD_ITEM);
    req.check     = in_accept && (cmd_t'(in_bus.command) == CMD_CHECK);
  end

  assign res_free = !out_valid_r || out_bus.ready;

  bpf_core #(
    .MAX_BINS   (MAX_BINS),
    .MAX_ITEMS  (MAX_ITEMS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .value    (value_ext[SIZE_WIDTH-1:0]),
    .res_free (res_free),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (status.done) begin
        out_valid_r      <= 1'b1;
        out_feasible_r   <= status.feasible;
        out_overflowed_r <= overflow_r;
        overflow_r       <= 1'b0;
      end else begin
        if (out_bus.ready) begin
          out_valid_r <= 1'b0;
        end
        if (status.dropped) begin
          overflow_r <= 1'b1;
        end
      end
    end
  end

  assign in_bus.ready       = status.idle;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.feasible   = out_feasible_r;
  assign out_bus.overflowed = out_overflowed_r;

endmodule

// ----- rtl/core/bpf_core.sv -----
// Search core: bin and item stores, sorted insertion and the backtracking
// search, all run by one sequencer.
// Depends on bpf_pkg.
module bpf_core #(
  parameter int MAX_BINS   = bpf_pkg::MAX_BINS_DEF,
  parameter int MAX_ITEMS  = bpf_pkg::MAX_ITEMS_DEF,
  parameter int SIZE_WIDTH = bpf_pkg::SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpf_pkg::req_t         req,
  input  logic [SIZE_WIDTH-1:0] value,
  input  logic                  res_free,
  output bpf_pkg::status_t      status
);
  import bpf_pkg::*;

  localparam int BW   = $clog2(MAX_BINS + 1);
  localparam int LW   = $clog2(MAX_ITEMS + 1);
  localparam int BIW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int IIW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int IXW  = (LW > BW) ? LW : BW;
  localparam int SUMW = SIZE_WIDTH + IXW;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT,
    S_SUMI_RD, S_SUMI_ADD, S_SUMB_RD, S_SUMB_ADD, S_TEST,
    S_LVL, S_LVL_SZ, S_SCAN, S_SCAN_RD, S_DUP, S_DUP_RD, S_PLACE,
    S_BACK, S_BACK_RD, S_BACK_ADD, S_FIN
  } state_t;

  state_t                state_r;
  logic [BW-1:0]         bin_count_r;
  logic [LW-1:0]         item_count_r;
  logic [LW-1:0]         level_r;
  logic [LW-1:0]         pos_r;
  logic [IXW-1:0]        idx_r;
  logic [BW-1:0]         b_r;
  logic [BW-1:0]         j_r;
  logic [SIZE_WIDTH-1:0] val_r;
  logic [SIZE_WIDTH-1:0] sz_r;
  logic [SIZE_WIDTH-1:0] cand_room_r;
  logic [SUMW-1:0]       need_r;
  logic [SUMW-1:0]       have_r;
  logic                  feasible_r;

  logic [SIZE_WIDTH-1:0] bin_mem   [MAX_BINS];
  logic [SIZE_WIDTH-1:0] item_mem  [MAX_ITEMS];
  logic [BIW-1:0]        stack_mem [MAX_ITEMS];
  logic [SIZE_WIDTH-1:0] bin_rd_r;
  logic [SIZE_WIDTH-1:0] item_rd_r;
  logic [BIW-1:0]        stack_rd_r;

  logic                  bin_we, item_we, stack_we;
  logic [BIW-1:0]        bin_waddr, bin_raddr;
  logic [IIW-1:0]        item_waddr, item_raddr;
  logic [SIZE_WIDTH-1:0] bin_wdata, item_wdata;
  logic [LW-1:0]         pos_dec, level_dec;
  logic                  bins_full, items_full;

  assign pos_dec    = pos_r - LW'(1);
  assign level_dec  = level_r - LW'(1);
  assign bins_full  = (bin_count_r == BW'(MAX_BINS));
  assign items_full = (item_count_r == LW'(MAX_ITEMS));

  always_comb begin
    bin_we     = 1'b0;
    bin_waddr  = b_r[BIW-1:0];
    bin_wdata  = cand_room_r - sz_r;
    bin_raddr  = '0;
    item_we    = 1'b0;
    item_waddr = pos_r[IIW-1:0];
    item_wdata = val_r;
    item_raddr = '0;
    stack_we   = (state_r == S_PLACE);
    case (state_r)
      S_IDLE: begin
        if (req.load_bin && !bins_full) begin
          bin_we    = 1'b1;
          bin_waddr = bin_count_r[BIW-1:0];
          bin_wdata = value;
        end
        if (req.load_item && !items_full && item_count_r == '0) begin
          item_we    = 1'b1;
          item_waddr = '0;
          item_wdata = value;
        end
      end
      S_INS_RD:  item_raddr = pos_dec[IIW-1:0];
      S_INS_CMP: begin
        item_we = 1'b1;
        if (item_rd_r < val_r) begin
          item_wdata = item_rd_r;
        end
      end
      S_INS_PUT:  item_we = 1'b1;
      S_SUMI_RD:  item_raddr = idx_r[IIW-1:0];
      S_SUMB_RD:  bin_raddr = idx_r[BIW-1:0];
      S_LVL:      item_raddr = level_r[IIW-1:0];
      S_SCAN:     bin_raddr = b_r[BIW-1:0];
      S_DUP:      bin_raddr = j_r[BIW-1:0];
      S_PLACE:    bin_we = 1'b1;
      S_BACK:     item_raddr = level_dec[IIW-1:0];
      S_BACK_RD:  bin_raddr = stack_rd_r;
      S_BACK_ADD: begin
        bin_we    = 1'b1;
        bin_wdata = bin_rd_r + sz_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    bin_rd_r <= bin_mem[bin_raddr];
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_waddr] <= item_wdata;
    end
    item_rd_r <= item_mem[item_raddr];
  end

  // The stack is read at the level below the current one while backtracking.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[level_r[IIW-1:0]] <= b_r[BIW-1:0];
    end
    stack_rd_r <= stack_mem[level_dec[IIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bin_count_r  <= '0;
      item_count_r <= '0;
      level_r      <= '0;
      feasible_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req.load_bin && !bins_full) begin
            bin_count_r <= bin_count_r + BW'(1);
          end
          if (req.load_item && !items_full) begin
            val_r <= value;
            pos_r <= item_count_r;
            if (item_count_r == '0) begin
              item_count_r <= item_count_r + LW'(1);
            end else begin
              state_r <= S_INS_RD;
            end
          end
          if (req.check) begin
            idx_r   <= '0;
            need_r  <= '0;
            have_r  <= '0;
            state_r <= S_SUMI_RD;
          end
        end
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          // A smaller neighbor moves up one place; otherwise the new size lands here.
          if (item_rd_r < val_r) begin
            pos_r   <= pos_dec;
            state_r <= (pos_dec == '0) ? S_INS_PUT : S_INS_RD;
          end else begin
            item_count_r <= item_count_r + LW'(1);
            state_r      <= S_IDLE;
          end
        end
        S_INS_PUT: begin
          item_count_r <= item_count_r + LW'(1);
          state_r      <= S_IDLE;
        end
        S_SUMI_RD: begin
          if (idx_r == IXW'(item_count_r)) begin
            idx_r   <= '0;
            state_r <= S_SUMB_RD;
          end else begin
            state_r <= S_SUMI_ADD;
          end
        end
        S_SUMI_ADD: begin
          need_r  <= need_r + SUMW'(item_rd_r);
          idx_r   <= idx_r + IXW'(1);
          state_r <= S_SUMI_RD;
        end
        S_SUMB_RD: begin
          state_r <= (idx_r == IXW'(bin_count_r)) ? S_TEST : S_SUMB_ADD;
        end
        S_SUMB_ADD: begin
          have_r  <= have_r + SUMW'(bin_rd_r);
          idx_r   <= idx_r + IXW'(1);
          state_r <= S_SUMB_RD;
        end
        S_TEST: begin
          // When the items outweigh the total room no packing can exist.
          if (need_r > have_r) begin
            feasible_r <= 1'b0;
            state_r    <= S_FIN;
          end else begin
            level_r <= '0;
            state_r <= S_LVL;
          end
        end
        S_LVL: begin
          if (level_r >= item_count_r) begin
            feasible_r <= 1'b1;
            state_r    <= S_FIN;
          end else begin
            state_r <= S_LVL_SZ;
          end
        end
        S_LVL_SZ: begin
          sz_r    <= item_rd_r;
          b_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          state_r <= (b_r >= bin_count_r) ? S_BACK : S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (bin_rd_r < sz_r) begin
            b_r     <= b_r + BW'(1);
            state_r <= S_SCAN;
          end else begin
            cand_room_r <= bin_rd_r;
            j_r         <= '0;
            state_r     <= S_DUP;
          end
        end
        S_DUP: begin
          state_r <= (j_r == b_r) ? S_PLACE : S_DUP_RD;
        end
        S_DUP_RD: begin
          // An earlier bin with the same room already covers this choice.
          if (bin_rd_r == cand_room_r) begin
            b_r     <= b_r + BW'(1);
            state_r <= S_SCAN;
          end else begin
            j_r     <= j_r + BW'(1);
            state_r <= S_DUP;
          end
        end
        S_PLACE: begin
          level_r <= level_r + LW'(1);
          state_r <= S_LVL;
        end
        S_BACK: begin
          if (level_r == '0) begin
            feasible_r <= 1'b0;
            state_r    <= S_FIN;
          end else begin
            level_r <= level_dec;
            state_r <= S_BACK_RD;
          end
        end
        S_BACK_RD: begin
          b_r     <= BW'(stack_rd_r);
          sz_r    <= item_rd_r;
          state_r <= S_BACK_ADD;
        end
        S_BACK_ADD: begin
          b_r     <= b_r + BW'(1);
          state_r <= S_SCAN;
        end
        S_FIN: begin
          if (res_free) begin
            bin_count_r  <= '0;
            item_count_r <= '0;
            level_r      <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    status.idle     = (state_r == S_IDLE);
    status.done     = (state_r == S_FIN) && res_free;
    status.feasible = feasible_r;
    status.dropped  = (state_r == S_IDLE) &&
                      ((req.load_bin && bins_full) || (req.load_item && items_full));
  end

endmodule

// ----- rtl/core/bpf_checker.sv -----
// Port-level checks for the bin packing feasibility block, attached by bind.
// Depends on bpf_pkg and the top level bin_packing_feasibility.
module bpf_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [bpf_pkg::CMD_W-1:0] in_command,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_feasible,
  input logic                      out_overflowed
);
  import bpf_pkg::*;

  // A result beat waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_feasible) && $stable(out_overflowed))
    else $error("result payload changed while stalled");

  // A check keeps the input side closed while the search runs.
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_CHECK) |=> !in_ready)
    else $error("input taken right after a check beat");

  // A new result only appears at the end of a check, never while idle.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result beat raised while the block was idle");

endmodule

bind bin_packing_feasibility bpf_port_checker u_bpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_command     (in_bus.command),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_feasible   (out_bus.feasible),
  .out_overflowed (out_bus.overflowed)
);

// ----- dv/bpf_checker.sv -----
// Scoreboard for the bin packing feasibility block: watches both channels,
// predicts each check verdict from the accepted load beats and compares.
// Depends on bpf_pkg and the channel interfaces in bpf_if.sv.
module bpf_checker (
  input  logic clk,
  input  logic rst_n,
  bpf_in_if    in_mon,
  bpf_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import bpf_pkg::*;

  localparam int NBINS  = MAX_BINS_DEF;
  localparam int NITEMS = MAX_ITEMS_DEF;
  localparam int SW     = SIZE_WIDTH_DEF;

  typedef struct packed {
    logic feasible;
    logic overflowed;
  } verdict_t;

  verdict_t      verdict_q[$];
  logic [SW-1:0] bin_cap[NBINS];
  logic [SW-1:0] item_sz[NITEMS];
  int            n_bins;
  int            n_items;
  logic          load_dropped;
  int            mismatches;

  // Depth-first placement, largest item first, bins in index order. A bin whose
  // room equals that of a lower bin is skipped, since it leads to the same subtree.
  function automatic logic packing_fits();
    logic [SW-1:0]   room[NBINS];
    int              home[NITEMS];
    longint unsigned need;
    longint unsigned have;
    int              lvl;
    int              start;
    int              b;
    int              c;
    int              j;
    logic            dup;
    need = 0;
    have = 0;
    for (j = 0; j < n_items; j++) need += item_sz[j];
    for (j = 0; j < n_bins; j++) begin
      have += bin_cap[j];
      room[j] = bin_cap[j];
    end
    if (need > have) return 1'b0;
    lvl = 0;
    start = 0;
    forever begin
      if (lvl >= n_items) return 1'b1;
      b = NBINS;
      for (c = start; c < n_bins && b == NBINS; c++) begin
        if (room[c] >= item_sz[lvl]) begin
          dup = 1'b0;
          for (j = 0; j < c; j++) if (room[j] == room[c]) dup = 1'b1;
          if (!dup) b = c;
        end
      end
      if (b < n_bins) begin
        room[b] -= item_sz[lvl];
        home[lvl] = b;
        lvl++;
        start = 0;
      end else begin
        if (lvl == 0) return 1'b0;
        lvl--;
        room[home[lvl]] += item_sz[lvl];
        start = home[lvl] + 1;
      end
    end
  endfunction

  task automatic apply_beat(logic [CMD_W-1:0] cmd, logic [SW-1:0] val);
    int       pos;
    verdict_t v;
    case (cmd_t'(cmd))
      CMD_LOAD_BIN: begin
        if (n_bins < NBINS) begin
          bin_cap[n_bins] = val;
          n_bins++;
        end else begin
          load_dropped = 1'b1;
        end
      end
      CMD_LOAD_ITEM: begin
        if (n_items < NITEMS) begin
          pos = n_items;
          while (pos > 0 && item_sz[pos-1] < val) begin
            item_sz[pos] = item_sz[pos-1];
            pos--;
          end
          item_sz[pos] = val;
          n_items++;
        end else begin
          load_dropped = 1'b1;
        end
      end
      CMD_CHECK: begin
        v.feasible   = packing_fits();
        v.overflowed = load_dropped;
        verdict_q.push_back(v);
        n_bins       = 0;
        n_items      = 0;
        load_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      verdict_q.delete();
      n_bins       = 0;
      n_items      = 0;
      load_dropped = 1'b0;
      mismatches   = 0;
    end else begin
      // The result beat is registered, so it never belongs to a check taken
      // at the same edge; settle it first.
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no check outstanding");
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.feasible !== want.feasible) begin
            $error("feasible: expected %0b, actual %0b", want.feasible, out_mon.feasible);
            mismatches++;
          end
          if (out_mon.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", want.overflowed,
                   out_mon.overflowed);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) apply_beat(in_mon.command, in_mon.value[SW-1:0]);
    end
    fail_count <= mismatches;
    pending    <= verdict_q.size();
  end

endmodule

// ----- dv/bin_packing_feasibility_tb.sv -----
// Top of the bin packing feasibility testbench: clock, reset, load and check
// stimulus with random idling on both channels, and the final verdict.
// Depends on bpf_pkg, bpf_if.sv, the block and dv/bpf_checker.sv.
module bin_packing_feasibility_tb;
  import bpf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int ITEM_GOAL  = 1100;
  localparam int QUIET_FROM = 950;
  localparam int HOLD_AT    = 3000;
  localparam int HOLD_LEN   = 500;
  localparam int LIMIT      = 8000000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   beats_sent = 0;
  int   idle_pct = 0;
  bit   quiet = 1'b0;

  bpf_in_if  in_ch ();
  bpf_out_if out_ch ();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bin_packing_feasibility dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  bpf_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Called at a falling edge; returns at a falling edge once the beat is taken.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_RESERVED) beats_sent++;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // One load-and-check sequence. Small problems keep the exhaustive search short;
  // full stores use contents that place greedily or fail on the total size.
  task automatic run_sequence();
    logic [VALUE_W-1:0] caps[$];
    logic [VALUE_W-1:0] sizes[$];
    int                 room[$];
    int                 pick;
    int                 nb;
    int                 ni;
    int                 top_val;
    int                 b;
    int                 k;
    int                 piece;
    int                 bi;
    int                 ii;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      if ($urandom_range(0, 1)) begin
        nb = $urandom_range(6, 10);
        ni = $urandom_range(0, 18);
        repeat (nb) caps.push_back(VALUE_W'($urandom_range(4096, 65535)));
        repeat (ni) sizes.push_back(VALUE_W'($urandom_range(0, 1023)));
      end else begin
        nb = $urandom_range(0, 10);
        ni = $urandom_range(14, 18);
        repeat (nb) caps.push_back(VALUE_W'($urandom_range(0, 4095)));
        repeat (ni) sizes.push_back(VALUE_W'($urandom_range(8192, 65535)));
      end
    end else if (pick < 12) begin
      // Stray beats with the unused code, often followed by a bare check.
      repeat ($urandom_range(1, 3))
        send_beat(CMD_RESERVED, VALUE_W'($urandom_range(0, 65535)));
      if ($urandom_range(0, 1)) send_beat(CMD_CHECK, VALUE_W'($urandom_range(0, 65535)));
      return;
    end else begin
      k = $urandom_range(0, 9);
      top_val = (k < 4) ? 15 : (k < 8) ? 255 : 65535;
      nb = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      ni = $urandom_range(0, (nb == 4) ? 5 : 6);
      repeat (nb) begin
        caps.push_back(VALUE_W'($urandom_range(0, top_val)));
        room.push_back(int'(caps[$]));
      end
      for (k = 0; k < ni; k++) begin
        if (pick < 75 && nb > 0) begin
          // Carve the items out of the bins so that a packing exists; whole
          // remainders make tight fits that force backtracking.
          b = $urandom_range(0, nb - 1);
          piece = $urandom_range(0, 1) ? room[b] : $urandom_range(0, room[b]);
          room[b] -= piece;
          sizes.push_back(VALUE_W'(piece));
        end else begin
          sizes.push_back(VALUE_W'($urandom_range(0, top_val)));
        end
      end
      if (pick >= 50 && pick < 75 && ni > 0) begin
        k = $urandom_range(0, ni - 1);
        if (sizes[k] != 16'hFFFF) sizes[k]++;
      end
    end
    bi = 0;
    ii = 0;
    while (bi < caps.size() || ii < sizes.size()) begin
      if ($urandom_range(0, 49) == 0)
        send_beat(CMD_RESERVED, VALUE_W'($urandom_range(0, 65535)));
      if (bi < caps.size() && (ii >= sizes.size() || $urandom_range(0, 1))) begin
        send_beat(CMD_LOAD_BIN, caps[bi]);
        bi++;
      end else begin
        send_beat(CMD_LOAD_ITEM, sizes[ii]);
        ii++;
      end
    end
    send_beat(CMD_CHECK, VALUE_W'($urandom_range(0, 65535)));
  endtask

  // Idling density changes every so often, including stretches with none.
  initial begin
    forever begin
      repeat (150) @(posedge clk);
      k_sel: case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (quiet) idle_pct = 0;
    end
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin
    int cyc;
    int n;
    bit held;
    cyc = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && cyc >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        cyc += HOLD_LEN - 1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        n = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
        cyc += n - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("bin_packing_feasibility regression: fail");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_LOAD_BIN;
    in_ch.value   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Nothing loaded at all, then an item with no bins.
    send_beat(CMD_CHECK, 16'h0000);
    send_beat(CMD_LOAD_ITEM, 16'd7);
    send_beat(CMD_CHECK, 16'hFFFF);
    // Full-scale values and a zero-size item.
    send_beat(CMD_LOAD_BIN, 16'hFFFF);
    send_beat(CMD_LOAD_ITEM, 16'hFFFF);
    send_beat(CMD_LOAD_ITEM, 16'h0000);
    send_beat(CMD_CHECK, 16'h5A5A);
    // Fits only after backtracking; two bins of equal room.
    send_beat(CMD_LOAD_BIN, 16'd10);
    send_beat(CMD_LOAD_ITEM, 16'd5);
    send_beat(CMD_LOAD_BIN, 16'd10);
    send_beat(CMD_LOAD_ITEM, 16'd6);
    send_beat(CMD_LOAD_BIN, 16'd6);
    send_beat(CMD_LOAD_ITEM, 16'd5);
    send_beat(CMD_LOAD_ITEM, 16'd5);
    send_beat(CMD_LOAD_ITEM, 16'd5);
    send_beat(CMD_CHECK, 16'hA5A5);
    send_beat(CMD_RESERVED, 16'hAAAA);
    send_beat(CMD_RESERVED, 16'h5555);
    // Total size exceeds total room.
    send_beat(CMD_LOAD_BIN, 16'd3);
    send_beat(CMD_LOAD_ITEM, 16'd2);
    send_beat(CMD_LOAD_ITEM, 16'd2);
    send_beat(CMD_CHECK, 16'h0001);

    while (beats_sent < ITEM_GOAL) begin
      if (beats_sent >= QUIET_FROM) quiet = 1'b1;
      run_sequence();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("bin_packing_feasibility regression: pass");
    end else begin
      $display("bin_packing_feasibility regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bpf_pkg.sv
rtl/core/bpf_if.sv
rtl/core/bpf_core.sv
rtl/core/bin_packing_feasibility.sv
rtl/core/bpf_checker.sv
dv/bpf_checker.sv
dv/bin_packing_feasibility_tb.sv
